// ===== sv/sfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream find/replace package
// Sequencer states, register indexes and the byte picker shared by the block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DROP,
        S_PUSH,
        S_REPL,
        S_FLUSH,
        S_MARK,
        S_DUMP,
        S_TAIL
    } t_state;

    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PAT_LO  = 3'd0;
    localparam t_cfg_idx CFG_PAT_HI  = 3'd1;
    localparam t_cfg_idx CFG_PAT_LEN = 3'd2;
    localparam t_cfg_idx CFG_REP_LO  = 3'd3;
    localparam t_cfg_idx CFG_REP_HI  = 3'd4;
    localparam t_cfg_idx CFG_REP_LEN = 3'd5;

    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 5;

    // Bytes at index 16 and above read as zero.
    function automatic logic [7:0] f_pick_byte(input logic [63:0] lo,
                                               input logic [63:0] hi,
                                               input logic [6:0]  idx);
        logic [127:0] w;
        w = {hi, lo};
        if (idx[6:4] == 3'd0) begin
            return w[{idx[3:0], 3'b000} +: 8];
        end
        return 8'h00;
    endfunction

endpackage
`default_nettype wire

// ===== sv/sfr_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream find/replace input channel
// Valid/ready channel carrying one text byte or an end-of-stream beat.
// ----------------------------------------------------------------------------
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] in_byte;

    modport source (output valid, output func, output in_byte, input ready);
    modport sink   (input valid, input func, input in_byte, output ready);
endinterface
`default_nettype wire

// ===== sv/sfr_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream find/replace output channel
// Valid/ready channel carrying one result byte or the end marker.
// ----------------------------------------------------------------------------
interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       stream_end;

    modport source (output valid, output out_byte, output byte_valid,
                    output last_of_run, output stream_end, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input last_of_run, input stream_end, output ready);
endinterface
`default_nettype wire

// ===== sv/stream_find_replace.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream find/replace
// Replaces every leftmost, non-overlapping occurrence of a pattern in a byte
// stream; unmatched bytes wait in a pending buffer while they are a prefix.
//
//   channel   dir  handshake       payload
//   i_in      in   valid/ready     func, in_byte
//   o_out     out  valid/ready     out_byte, byte_valid, last_of_run, stream_end
//   cfg       in   i_cfg_we        i_cfg_idx, i_cfg_data
//
// One beat is taken in a cycle, then the block is busy. Each prefix check runs
// one compare per cycle over the pending bytes, and every result goes out
// through the output register; a byte is stored, checked and its results
// sent, and end of stream sends the pending bytes, then the end marker.
// Output stalls hold the sequencer; a waiting result does not block i_in.
// Reset is synchronous; pending buffer contents are not cleared.
// ----------------------------------------------------------------------------
module stream_find_replace #(
    parameter int MAX_PATTERN     = 16,
    parameter int MAX_REPLACEMENT = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    sfr_in_if.sink                         i_in,
    sfr_out_if.source                      o_out,
    input  wire                            i_cfg_we,
    input  wire sfr_pkg::t_cfg_idx         i_cfg_idx,
    input  wire [sfr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sfr_pkg::*;

    localparam int MAXI = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
    localparam int IW   = (MAXI > 1) ? $clog2(MAXI) : 1;
    localparam int PW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CW   = $clog2(MAX_PATTERN + 1);
    localparam logic [6:0] MAXP7 = 7'(MAX_PATTERN);
    localparam logic [6:0] MAXR7 = 7'(MAX_REPLACEMENT);

    // configuration
    logic [63:0]      r_pat_lo, r_pat_hi, r_rep_lo, r_rep_hi;
    logic [LEN_W-1:0] r_pat_len, r_rep_len;

    // sequencer and datapath
    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [IW-1:0]    r_idx, n_idx;
    logic [7:0]       r_byte, n_byte;
    logic [7:0]       r_hold_byte, n_hold_byte;
    logic             r_hold_vld, n_hold_vld;
    logic             r_push_last, n_push_last;
    logic             r_do_repl, n_do_repl;
    logic [7:0]       r_pend [MAX_PATTERN];

    // output register
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_bv, n_out_bv;
    logic             r_out_last, n_out_last;
    logic             r_out_end, n_out_end;

    logic             accept, out_free, eq, last_idx, full, rep_last;
    logic             pend_wr, pend_shift;
    logic [6:0]       plen7, rl7;
    logic [7:0]       pend_rd, pat_rd, rep_rd;

    always_comb begin
        if (r_pat_len == '0) begin
            plen7 = 7'd1;
        end else if ({2'b00, r_pat_len} > MAXP7) begin
            plen7 = MAXP7;
        end else begin
            plen7 = {2'b00, r_pat_len};
        end
        rl7 = ({2'b00, r_rep_len} > MAXR7) ? MAXR7 : {2'b00, r_rep_len};
    end

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // shared compare unit
    assign pend_rd  = r_pend[r_idx[PW-1:0]];
    assign pat_rd   = f_pick_byte(r_pat_lo, r_pat_hi, 7'(r_idx));
    assign rep_rd   = f_pick_byte(r_rep_lo, r_rep_hi, 7'(r_idx));
    assign eq       = (pend_rd == pat_rd);
    assign last_idx = (7'(r_idx) + 7'd1 == 7'(r_count));
    assign full     = (7'(r_count) == plen7);
    assign rep_last = (7'(r_idx) + 7'd1 == rl7);

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.byte_valid  = r_out_bv;
    assign o_out.last_of_run = r_out_last;
    assign o_out.stream_end  = r_out_end;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.func) begin
                        n_state = (r_count == '0) ? S_MARK : S_FLUSH;
                    end else if (7'(r_count) >= plen7) begin
                        n_state = S_DUMP;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (!eq) begin
                    n_state = S_DROP;
                end else if (last_idx) begin
                    if (r_hold_vld) begin
                        n_state = S_PUSH;
                    end else if (full && rl7 != 7'd0) begin
                        n_state = S_REPL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DROP: begin
                if (!r_hold_vld || out_free) begin
                    n_state = (r_count == CW'(1)) ? S_PUSH : S_CHECK;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = r_do_repl ? S_REPL : S_IDLE;
                end
            end
            S_REPL: begin
                if (out_free && rep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (out_free && r_count == CW'(1)) begin
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (out_free && r_count == CW'(1)) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_byte      = r_byte;
        n_hold_byte = r_hold_byte;
        n_hold_vld  = r_hold_vld;
        n_push_last = r_push_last;
        n_do_repl   = r_do_repl;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_bv    = r_out_bv;
        n_out_last  = r_out_last;
        n_out_end   = r_out_end;
        pend_wr     = 1'b0;
        pend_shift  = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_idx  = '0;
                n_byte = i_in.in_byte;
                if (accept && !i_in.func && 7'(r_count) < plen7) begin
                    pend_wr = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            S_CHECK: begin
                if (eq && !last_idx) begin
                    n_idx = r_idx + IW'(1);
                end else if (eq) begin
                    n_idx       = '0;
                    n_push_last = !(full && rl7 != 7'd0);
                    n_do_repl   = full && rl7 != 7'd0;
                    if (full) begin
                        n_count = '0;
                    end
                end
            end
            S_DROP: begin
                if (!r_hold_vld || out_free) begin
                    if (r_hold_vld) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = r_hold_byte;
                        n_out_bv    = 1'b1;
                        n_out_last  = 1'b0;
                        n_out_end   = 1'b0;
                    end
                    n_hold_byte = r_pend[0];
                    n_hold_vld  = 1'b1;
                    pend_shift  = 1'b1;
                    n_count     = r_count - CW'(1);
                    n_idx       = '0;
                    n_push_last = 1'b1;
                    n_do_repl   = 1'b0;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_hold_byte;
                    n_out_bv    = 1'b1;
                    n_out_last  = r_push_last;
                    n_out_end   = 1'b0;
                    n_hold_vld  = 1'b0;
                    n_idx       = '0;
                end
            end
            S_REPL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = rep_rd;
                    n_out_bv    = 1'b1;
                    n_out_last  = rep_last;
                    n_out_end   = 1'b0;
                    n_idx       = r_idx + IW'(1);
                end
            end
            S_FLUSH, S_DUMP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_pend[0];
                    n_out_bv    = 1'b1;
                    n_out_last  = 1'b0;
                    n_out_end   = 1'b0;
                    pend_shift  = 1'b1;
                    n_count     = r_count - CW'(1);
                end
            end
            S_MARK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = 8'h00;
                    n_out_bv    = 1'b0;
                    n_out_last  = 1'b1;
                    n_out_end   = 1'b1;
                end
            end
            S_TAIL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_byte;
                    n_out_bv    = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_end   = 1'b0;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= LEN_W'(1);
            r_rep_lo  <= '0;
            r_rep_hi  <= '0;
            r_rep_len <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                CFG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                CFG_PAT_LEN: r_pat_len <= i_cfg_data[LEN_W-1:0];
                CFG_REP_LO:  r_rep_lo  <= i_cfg_data;
                CFG_REP_HI:  r_rep_hi  <= i_cfg_data;
                CFG_REP_LEN: r_rep_len <= i_cfg_data[LEN_W-1:0];
                default: begin
                    r_pat_len <= r_pat_len;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_hold_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_hold_vld  <= n_hold_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_byte      <= n_byte;
        r_hold_byte <= n_hold_byte;
        r_push_last <= n_push_last;
        r_do_repl   <= n_do_repl;
        r_out_byte  <= n_out_byte;
        r_out_bv    <= n_out_bv;
        r_out_last  <= n_out_last;
        r_out_end   <= n_out_end;
    end

    // pending buffer: append at the fill level, drop from the front
    always_ff @(posedge i_clk) begin
        if (pend_wr) begin
            r_pend[r_count[PW-1:0]] <= i_in.in_byte;
        end else if (pend_shift) begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                r_pend[i] <= r_pend[i + 1];
            end
        end
    end

`ifndef SYNTHESIS
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_vld)
        else $error("held byte left over when idle");

    a_check_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_count != '0 && 7'(r_count) <= plen7
                                  && 7'(r_idx) < 7'(r_count)))
        else $error("prefix check out of range");

    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end) |-> (r_out_last && !r_out_bv))
        else $error("end marker malformed");

    a_mark_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK && out_free) |=> (r_count == '0 && r_state == S_IDLE))
        else $error("pending bytes left after end of stream");

    a_repl_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPL) |-> (7'(r_idx) < rl7 && r_count == '0))
        else $error("replacement index out of range");
`endif

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream find/replace testbench
// Feeds byte streams with embedded pattern occurrences, partial prefixes and
// end-of-stream beats under changing register settings. An in-bench text
// substitution predictor builds the expected output beats, and every output
// beat is checked field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module tb;
    import sfr_pkg::*;

    localparam int SETTLE_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 160;
    localparam int MAX_BYTES      = 16;

    typedef enum logic {
        FN_DATA = 1'b0,
        FN_END  = 1'b1
    } t_func;

    typedef struct packed {
        t_func      func;
        logic [7:0] in_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_of_run;
        logic       stream_end;
    } t_result;

    logic            i_clk;
    logic            i_rst_n;
    logic            cfg_we;
    t_cfg_idx        cfg_idx;
    logic [63:0]     cfg_data;

    sfr_in_if  in_ch ();
    sfr_out_if out_ch ();

    stream_find_replace i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    t_item   send_q [$];
    t_result expected_q [$];

    logic [7:0] pat_b  [MAX_BYTES];
    logic [7:0] rep_b  [MAX_BYTES];
    logic [7:0] held   [MAX_BYTES];
    int         pat_len;
    int         rep_len;
    int         held_cnt;

    int errors;
    int beats_in;
    int beats_out;
    int repl_count;
    int end_count;
    int settings_count;

    int burst_left;
    int gap_left;
    int hold_left;
    int next_hold_at;
    int stall_pct;
    int tick;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("ERROR @%0t: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    function automatic t_result mk_result(input logic [7:0] b, input logic bv,
                                          input logic se);
        t_result r;
        r.out_byte    = b;
        r.byte_valid  = bv;
        r.last_of_run = 1'b0;
        r.stream_end  = se;
        return r;
    endfunction

    function automatic bit held_is_prefix(input int n);
        for (int i = 0; i < n; i++) begin
            if (held[i] != pat_b[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic find_replace_step(input t_func fn, input logic [7:0] b);
        t_result run [$];
        if (fn == FN_END) begin
            for (int i = 0; i < held_cnt; i++) run.push_back(mk_result(held[i], 1'b1, 1'b0));
            held_cnt = 0;
            run.push_back(mk_result(8'h00, 1'b0, 1'b1));
            end_count++;
        end else if (held_cnt >= pat_len) begin
            for (int i = 0; i < held_cnt; i++) run.push_back(mk_result(held[i], 1'b1, 1'b0));
            run.push_back(mk_result(b, 1'b1, 1'b0));
            held_cnt = 0;
        end else begin
            held[held_cnt] = b;
            held_cnt++;
            forever begin
                if (held_cnt == pat_len && held_is_prefix(pat_len)) begin
                    for (int i = 0; i < rep_len; i++)
                        run.push_back(mk_result(rep_b[i], 1'b1, 1'b0));
                    held_cnt = 0;
                    repl_count++;
                    break;
                end
                if (held_cnt < pat_len && held_is_prefix(held_cnt)) break;
                run.push_back(mk_result(held[0], 1'b1, 1'b0));
                for (int i = 1; i < held_cnt; i++) held[i - 1] = held[i];
                held_cnt--;
            end
        end
        if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[i]) expected_q.push_back(run[i]);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        t_item nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                find_replace_step(t_func'(in_ch.func), in_ch.in_byte);
                beats_in++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (send_q.size() > 0) begin
                    nxt = send_q.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.func    <= nxt.func;
                    in_ch.in_byte <= nxt.in_byte;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall rate is redrawn at regular ticks; long hold-offs at set points.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left    = 0;
            next_hold_at = 60;
            stall_pct    = 0;
            tick         = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.out_byte    = out_ch.out_byte;
                got.byte_valid  = out_ch.byte_valid;
                got.last_of_run = out_ch.last_of_run;
                got.stream_end  = out_ch.stream_end;
                beats_out++;
                if (expected_q.size() == 0) begin
                    report("result beat with nothing outstanding", got.out_byte, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.out_byte !== want.out_byte)
                        report("out_byte", got.out_byte, want.out_byte);
                    if (got.byte_valid !== want.byte_valid)
                        report("byte_valid", got.byte_valid, want.byte_valid);
                    if (got.last_of_run !== want.last_of_run)
                        report("last_of_run", got.last_of_run, want.last_of_run);
                    if (got.stream_end !== want.stream_end)
                        report("stream_end", got.stream_end, want.stream_end);
                end
            end
            tick++;
            if (tick % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 85;
                endcase
            end
            if (hold_left == 0 && beats_in >= next_hold_at) begin
                hold_left    = HOLD_CYCLES;
                next_hold_at = next_hold_at + 90;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR @%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] data);
        int n;
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        n = int'(data[4:0]);
        case (idx)
            CFG_PAT_LO: for (int i = 0; i < 8; i++) pat_b[i] = data[8 * i +: 8];
            CFG_PAT_HI: for (int i = 0; i < 8; i++) pat_b[i + 8] = data[8 * i +: 8];
            CFG_PAT_LEN: pat_len = (n == 0) ? 1 : ((n > MAX_BYTES) ? MAX_BYTES : n);
            CFG_REP_LO: for (int i = 0; i < 8; i++) rep_b[i] = data[8 * i +: 8];
            CFG_REP_HI: for (int i = 0; i < 8; i++) rep_b[i + 8] = data[8 * i +: 8];
            CFG_REP_LEN: rep_len = (n > MAX_BYTES) ? MAX_BYTES : n;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [63:0] plo, input logic [63:0] phi,
                                  input int plen, input logic [63:0] rlo,
                                  input logic [63:0] rhi, input int rlen);
        write_reg(CFG_PAT_LO, plo);
        write_reg(CFG_PAT_HI, phi);
        write_reg(CFG_PAT_LEN, 64'(plen));
        write_reg(CFG_REP_LO, rlo);
        write_reg(CFG_REP_HI, rhi);
        write_reg(CFG_REP_LEN, 64'(rlen));
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
        settings_count++;
    endtask

    task automatic queue_byte(input logic [7:0] b);
        t_item it;
        it.func    = FN_DATA;
        it.in_byte = b;
        send_q.push_back(it);
    endtask

    task automatic queue_end();
        t_item it;
        it.func    = FN_END;
        it.in_byte = 8'($urandom);
        send_q.push_back(it);
    endtask

    task automatic queue_prefix(input int n);
        for (int i = 0; i < n; i++) queue_byte(pat_b[i]);
    endtask

    // Hold until every beat is taken and answered, then let the block settle.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (send_q.size() != 0 || in_ch.valid || expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_phase(input int phase_no, input int n_items);
        logic [7:0]  pb [MAX_BYTES];
        logic [7:0]  base;
        logic [63:0] plo;
        logic [63:0] phi;
        bit          narrow;
        int          plen;
        int          rlen;
        int          count;
        int          sel;
        int          k;
        case (phase_no)
            0: plen = 1;
            1: plen = MAX_BYTES;
            default: plen = ($urandom_range(0, 3) == 0) ? $urandom_range(7, MAX_BYTES)
                                                        : $urandom_range(1, 6);
        endcase
        case (phase_no % 4)
            0: rlen = 0;
            1: rlen = MAX_BYTES;
            default: rlen = $urandom_range(0, MAX_BYTES);
        endcase
        narrow = 1'($urandom_range(0, 1));
        base   = 8'($urandom);
        for (int i = 0; i < MAX_BYTES; i++)
            pb[i] = narrow ? base + 8'($urandom_range(0, 1)) : 8'($urandom);
        for (int i = 0; i < 8; i++) begin
            plo[8 * i +: 8] = pb[i];
            phi[8 * i +: 8] = pb[i + 8];
        end
        apply_settings(plo, phi, plen, {$urandom, $urandom}, {$urandom, $urandom}, rlen);
        count = 0;
        while (count < n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                queue_prefix(pat_len);
                count += pat_len;
            end else if (sel < 55) begin
                k = $urandom_range(0, pat_len - 1);
                queue_prefix(k);
                queue_byte(8'($urandom));
                count += k + 1;
            end else if (sel < 80) begin
                queue_byte(pat_b[$urandom_range(0, pat_len - 1)]);
                count++;
            end else if (sel < 95) begin
                queue_byte(8'($urandom));
                count++;
            end else begin
                queue_end();
                count++;
            end
        end
        if ($urandom_range(0, 1) == 1) queue_end();
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.func    = FN_DATA;
        in_ch.in_byte = 8'h00;
        out_ch.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_PAT_LO;
        cfg_data      = 64'h0;
        for (int i = 0; i < MAX_BYTES; i++) begin
            pat_b[i] = 8'h00;
            rep_b[i] = 8'h00;
            held[i]  = 8'h00;
        end
        pat_len        = 1;
        rep_len        = 0;
        held_cnt       = 0;
        errors         = 0;
        beats_in       = 0;
        beats_out      = 0;
        repl_count     = 0;
        end_count      = 0;
        settings_count = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: single zero byte pattern, empty replacement deletes it
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h5A);
        queue_end();
        wait_drained();

        apply_settings(64'h0000_0000_0063_6261, 64'h0, 3,
                       64'h0000_0056_575A_5958, 64'hFFFF_FFFF_FFFF_FFFF, 5);
        queue_prefix(3);
        queue_byte(8'h61);
        queue_prefix(3);
        queue_prefix(2);
        queue_end();
        wait_drained();

        // hold three bytes under a full-length pattern, then shorten it
        apply_settings(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, MAX_BYTES,
                       64'h0, 64'hFFFF_FFFF_FFFF_FFFF, MAX_BYTES);
        queue_byte(8'hFF);
        queue_byte(8'hFF);
        queue_byte(8'hFF);
        wait_drained();

        apply_settings(64'h0000_0000_0000_7771, 64'h0, 2, 64'h2A, 64'h0, 1);
        queue_byte(8'h10);
        queue_byte(8'h71);
        wait_drained();

        // change pattern bytes while one byte is held
        apply_settings(64'h0000_0000_0000_7772, 64'h0, 2, 64'h2A, 64'h0, 1);
        queue_byte(8'h72);
        queue_end();
        wait_drained();

        for (int p = 0; p < 8; p++) random_phase(p, 26);

        if (expected_q.size() != 0)
            report("result beats never delivered", expected_q.size(), 0);
        $display("Covered %0d input beats (%0d stream ends) under %0d register settings",
                 beats_in, end_count, settings_count);
        $display("Checked %0d result beats, %0d pattern replacements",
                 beats_out, repl_count);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
